>>> hw/rtl/brlb_pkg.sv
// Shared types and constants of the block ring log buffer.
package brlb_pkg;

   localparam int BLOCK_NUM_W = 3;
   localparam int SLOT_NUM_W  = 4;
   localparam int ENTRY_W     = 32;

   localparam logic CMD_APPEND = 1'b0;
   localparam logic CMD_FETCH  = 1'b1;

   typedef struct packed {
      logic load;
      logic exec;
   } ctrl_cmd_type;

endpackage

>>> hw/rtl/brlb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module brlb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/brlb_ctrl.sv
// Controller state machine that sequences each transaction through the datapath.
module brlb_ctrl
   import brlb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   output logic         rsp_valid,
   output ctrl_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign accept = start && !busy_ff;

   always_comb begin
      state_in     = state_ff;
      busy_in      = busy_ff;
      rsp_valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
               busy_in  = 1'b1;
            end
         end
         ST_EXEC: begin
            state_in     = ST_RESP;
            rsp_valid_in = 1'b1;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
            busy_in  = 1'b0;
         end
         default: begin
            state_in = ST_IDLE;
            busy_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign cmd.load  = accept;
   assign cmd.exec  = (state_ff == ST_EXEC);

`ifndef NO_ASSERTIONS
   a_accept_sets_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after an accepted transaction");

   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("response strobe missing two cycles after acceptance");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe lasted more than one cycle");

   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response strobe while not busy");
`endif

endmodule

>>> hw/rtl/brlb_dpath.sv
// Datapath: ring pointers, block full flags, entry RAM and result registers.
module brlb_dpath
   import brlb_pkg::*;
#(
   parameter int BLOCKS          = 8,
   parameter int SLOTS_PER_BLOCK = 16,
   parameter int DATA_WIDTH      = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ctrl_cmd_type           cmd,
   input  logic                   req_cmd,
   input  logic [ENTRY_W-1:0]     req_entry_data,
   output logic                   rsp_found,
   output logic [BLOCK_NUM_W-1:0] rsp_block_number,
   output logic [SLOT_NUM_W-1:0]  rsp_slot_number,
   output logic [ENTRY_W-1:0]     rsp_read_data,
   output logic                   rsp_reader_skipped
);

   localparam int BW    = $clog2(BLOCKS);
   localparam int SW    = (SLOTS_PER_BLOCK > 1) ? $clog2(SLOTS_PER_BLOCK) : 1;
   localparam int DEPTH = BLOCKS * SLOTS_PER_BLOCK;
   localparam int AW    = $clog2(DEPTH);

   // Captured transaction.
   logic               cmd_ff;
   logic [ENTRY_W-1:0] data_ff;

   // Ring state. Only the writer's block can be partly filled; every other
   // block is either full or empty, which one flag per block records.
   logic [BW-1:0]     wblk_ff, wblk_in;
   logic [SW-1:0]     wfill_ff, wfill_in;
   logic [BW-1:0]     rblk_ff, rblk_in;
   logic [SW-1:0]     rslot_ff, rslot_in;
   logic [BLOCKS-1:0] full_ff, full_in;

   // Result registers.
   logic          res_found_ff, res_found_in;
   logic [BW-1:0] res_blk_ff, res_blk_in;
   logic [SW-1:0] res_slot_ff, res_slot_in;
   logic          res_skip_ff, res_skip_in;
   logic          res_hit_ff, res_hit_in;

   logic                  ram_we, ram_re;
   logic [AW-1:0]         ram_waddr, ram_raddr;
   logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;
   logic [63:0]           wide_wr, wide_rd;
   logic [31:0]           blk_ext, slot_ext;
   logic [BW-1:0]         wnext;
   logic                  avail;

   function automatic logic [BW-1:0] ring_next(input logic [BW-1:0] b);
      return (b == BW'(BLOCKS - 1)) ? '0 : b + 1'b1;
   endfunction

   function automatic logic [AW-1:0] slot_addr(input logic [BW-1:0] b,
                                               input logic [SW-1:0] s);
      return AW'(b) * AW'(SLOTS_PER_BLOCK) + AW'(s);
   endfunction

   assign wide_wr   = 64'(data_ff);
   assign ram_wdata = wide_wr[DATA_WIDTH-1:0];
   assign ram_waddr = slot_addr(wblk_ff, wfill_ff);
   assign ram_raddr = slot_addr(rblk_ff, rslot_ff);
   assign wnext     = ring_next(wblk_ff);
   assign avail     = (rblk_ff == wblk_ff) ? (rslot_ff < wfill_ff) : full_ff[rblk_ff];

   always_comb begin
      wblk_in      = wblk_ff;
      wfill_in     = wfill_ff;
      rblk_in      = rblk_ff;
      rslot_in     = rslot_ff;
      full_in      = full_ff;
      res_found_in = res_found_ff;
      res_blk_in   = res_blk_ff;
      res_slot_in  = res_slot_ff;
      res_skip_in  = res_skip_ff;
      res_hit_in   = res_hit_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      if (cmd.exec) begin
         if (cmd_ff == CMD_APPEND) begin
            ram_we       = 1'b1;
            res_found_in = 1'b1;
            res_blk_in   = wblk_ff;
            res_slot_in  = wfill_ff;
            res_skip_in  = 1'b0;
            res_hit_in   = 1'b0;
            if (wfill_ff == SW'(SLOTS_PER_BLOCK - 1)) begin
               // The block is now full: move the writer on and empty the next block.
               full_in[wblk_ff] = 1'b1;
               full_in[wnext]   = 1'b0;
               wblk_in          = wnext;
               wfill_in         = '0;
               if (wnext == rblk_ff) begin
                  rblk_in     = ring_next(rblk_ff);
                  rslot_in    = '0;
                  res_skip_in = 1'b1;
               end
            end else begin
               wfill_in = wfill_ff + 1'b1;
            end
         end else begin
            ram_re       = 1'b1;
            res_found_in = avail;
            res_blk_in   = rblk_ff;
            res_slot_in  = rslot_ff;
            res_skip_in  = 1'b0;
            res_hit_in   = avail && (cmd_ff == CMD_FETCH);
            if (avail) begin
               if (rslot_ff == SW'(SLOTS_PER_BLOCK - 1)) begin
                  rblk_in  = ring_next(rblk_ff);
                  rslot_in = '0;
               end else begin
                  rslot_in = rslot_ff + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wblk_ff  <= '0;
         wfill_ff <= '0;
         rblk_ff  <= '0;
         rslot_ff <= '0;
         full_ff  <= '0;
      end else begin
         wblk_ff  <= wblk_in;
         wfill_ff <= wfill_in;
         rblk_ff  <= rblk_in;
         rslot_ff <= rslot_in;
         full_ff  <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff  <= req_cmd;
         data_ff <= req_entry_data;
      end
      res_found_ff <= res_found_in;
      res_blk_ff   <= res_blk_in;
      res_slot_ff  <= res_slot_in;
      res_skip_ff  <= res_skip_in;
      res_hit_ff   <= res_hit_in;
   end

   brlb_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign wide_rd            = 64'(ram_rdata);
   assign blk_ext            = 32'(res_blk_ff);
   assign slot_ext           = 32'(res_slot_ff);
   assign rsp_found          = res_found_ff;
   assign rsp_block_number   = blk_ext[BLOCK_NUM_W-1:0];
   assign rsp_slot_number    = slot_ext[SLOT_NUM_W-1:0];
   assign rsp_read_data      = res_hit_ff ? wide_rd[ENTRY_W-1:0] : '0;
   assign rsp_reader_skipped = res_skip_ff;

`ifndef NO_ASSERTIONS
   a_reader_behind_writer: assert property (@(posedge clock) disable iff (reset)
      (rblk_ff == wblk_ff) |-> (rslot_ff <= wfill_ff))
      else $error("reader ahead of writer within the shared block");

   a_skip_only_on_append: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && cmd_ff == CMD_FETCH) |=> !res_skip_ff)
      else $error("reader skip flagged on a fetch");
`endif

endmodule

>>> hw/rtl/block_ring_log_buffer_unit.sv
// Top level of the block ring log buffer: controller, datapath and entry RAM.
// A transaction accepted in the idle state moves to the execute state, where the
// result registers and the response strobe are loaded; the strobe is then high in
// the respond state. Busy stays high through execute and respond, so no new
// transaction is taken before the controller is idle again; the receiver cannot stall.
// Reset clears the ring pointers and block flags at once; the entry RAM is not cleared.
module block_ring_log_buffer_unit
   import brlb_pkg::*;
#(
   parameter int BLOCKS          = 8,
   parameter int SLOTS_PER_BLOCK = 16,
   parameter int DATA_WIDTH      = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_cmd,
   input  logic [ENTRY_W-1:0]     req_entry_data,
   output logic                   rsp_valid,
   output logic                   rsp_found,
   output logic [BLOCK_NUM_W-1:0] rsp_block_number,
   output logic [SLOT_NUM_W-1:0]  rsp_slot_number,
   output logic [ENTRY_W-1:0]     rsp_read_data,
   output logic                   rsp_reader_skipped
);

   ctrl_cmd_type cmd;

   brlb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   brlb_dpath #(
      .BLOCKS          (BLOCKS),
      .SLOTS_PER_BLOCK (SLOTS_PER_BLOCK),
      .DATA_WIDTH      (DATA_WIDTH)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_cmd            (req_cmd),
      .req_entry_data     (req_entry_data),
      .rsp_found          (rsp_found),
      .rsp_block_number   (rsp_block_number),
      .rsp_slot_number    (rsp_slot_number),
      .rsp_read_data      (rsp_read_data),
      .rsp_reader_skipped (rsp_reader_skipped)
   );

endmodule

>>> tb/block_ring_log_buffer_unit_tb.sv
// Self-checking testbench of the block ring log buffer: directed table, then random traffic.
`timescale 1ns / 1ps

module block_ring_log_buffer_unit_tb;
   import brlb_pkg::*;

   localparam int RING_BLOCKS  = 8;
   localparam int RING_SLOTS   = 16;
   localparam int RANDOM_ITEMS = 2000;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int MAX_SHOWN    = 10;

   typedef struct packed {
      logic                   found;
      logic [BLOCK_NUM_W-1:0] block_number;
      logic [SLOT_NUM_W-1:0]  slot_number;
      logic [ENTRY_W-1:0]     read_data;
      logic                   reader_skipped;
   } log_result_type;

   typedef struct packed {
      logic               cmd;
      logic [ENTRY_W-1:0] entry_data;
      logic               given;
      log_result_type     res;
   } table_row_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic                   req_cmd = CMD_APPEND;
   logic [ENTRY_W-1:0]     req_entry_data = '0;
   logic                   rsp_valid;
   logic                   rsp_found;
   logic [BLOCK_NUM_W-1:0] rsp_block_number;
   logic [SLOT_NUM_W-1:0]  rsp_slot_number;
   logic [ENTRY_W-1:0]     rsp_read_data;
   logic                   rsp_reader_skipped;

   // Shadow copy of the ring state.
   logic [ENTRY_W-1:0]     log_entries [RING_BLOCKS*RING_SLOTS];
   int unsigned            block_fill [RING_BLOCKS];
   int unsigned            wr_block;
   int unsigned            rd_block;
   int unsigned            rd_slot;

   log_result_type         pending_rsp_q [$];
   table_row_type          table_rsp_q [$];
   int                     mismatch_count = 0;
   int                     cycle_count = 0;

   block_ring_log_buffer_unit u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_cmd            (req_cmd),
      .req_entry_data     (req_entry_data),
      .rsp_valid          (rsp_valid),
      .rsp_found          (rsp_found),
      .rsp_block_number   (rsp_block_number),
      .rsp_slot_number    (rsp_slot_number),
      .rsp_read_data      (rsp_read_data),
      .rsp_reader_skipped (rsp_reader_skipped)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned next_block(int unsigned b);
      return (b + 1 >= RING_BLOCKS) ? 0 : b + 1;
   endfunction

   // Applies one transaction to the shadow ring and returns the response it should give.
   function automatic log_result_type apply_log_op(logic cmd, logic [ENTRY_W-1:0] word);
      log_result_type r;
      int unsigned    blk;
      int unsigned    slot;
      r = '0;
      if (cmd == CMD_APPEND) begin
         blk  = wr_block;
         slot = block_fill[blk] % RING_SLOTS;
         log_entries[blk*RING_SLOTS + slot] = word;
         block_fill[blk] = slot + 1;
         r.found = 1'b1;
         if (block_fill[blk] >= RING_SLOTS) begin
            wr_block = next_block(blk);
            block_fill[wr_block] = 0;
            // The writer has caught the reader up, so the oldest block is dropped.
            if (wr_block == rd_block) begin
               rd_block = next_block(rd_block);
               rd_slot  = 0;
               r.reader_skipped = 1'b1;
            end
         end
      end else begin
         blk  = rd_block;
         slot = rd_slot;
         if (slot < block_fill[blk] && slot < RING_SLOTS) begin
            r.read_data = log_entries[blk*RING_SLOTS + slot];
            r.found     = 1'b1;
            rd_slot     = slot + 1;
            if (rd_slot >= RING_SLOTS) begin
               rd_block = next_block(blk);
               rd_slot  = 0;
            end
         end
      end
      r.block_number = blk[BLOCK_NUM_W-1:0];
      r.slot_number  = slot[SLOT_NUM_W-1:0];
      return r;
   endfunction

   task automatic note_mismatch(string what, log_result_type want, log_result_type got);
      if (mismatch_count < MAX_SHOWN) begin
         $display("%0t: %s: expected found=%b blk=%0d slot=%0d data=%h skip=%b,",
                  $time, what, want.found, want.block_number, want.slot_number,
                  want.read_data, want.reader_skipped);
         $display("   got found=%b blk=%0d slot=%0d data=%h skip=%b",
                  got.found, got.block_number, got.slot_number, got.read_data,
                  got.reader_skipped);
      end
      mismatch_count++;
   endtask

   // Checks responses, then records the transaction taken at this edge.
   always @(posedge clock) begin
      log_result_type got;
      log_result_type want;
      table_row_type  row;
      if (!reset) begin
         if (rsp_valid) begin
            got = '{rsp_found, rsp_block_number, rsp_slot_number, rsp_read_data,
                    rsp_reader_skipped};
            if (pending_rsp_q.size() == 0) begin
               note_mismatch("response with nothing outstanding", '0, got);
            end else begin
               want = pending_rsp_q.pop_front();
               if (got !== want) begin
                  note_mismatch("response mismatch", want, got);
               end
            end
         end
         if (start && !busy) begin
            want = apply_log_op(req_cmd, req_entry_data);
            row  = table_rsp_q.pop_front();
            if (row.given) begin
               want = row.res;
            end
            pending_rsp_q.push_back(want);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("block_ring_log_buffer_unit_tb: done, errors");
         $finish;
      end
   end

   // Presents one transaction and returns at the edge that takes it; start stays high.
   task automatic send_op(table_row_type row);
      table_rsp_q.push_back(row);
      req_cmd        <= row.cmd;
      req_entry_data <= row.entry_data;
      start          <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic drain_responses();
      start <= 1'b0;
      @(posedge clock);
      while (pending_rsp_q.size() != 0) @(posedge clock);
   endtask

   table_row_type dir_table [24];

   initial begin
      table_row_type row;
      int            sent;
      int            append_pct;
      int            phase_len;
      int            burst_len;
      int            gap;
      int            phase_no;

      for (int b = 0; b < RING_BLOCKS; b++) block_fill[b] = 0;
      wr_block = 0;
      rd_block = 0;
      rd_slot  = 0;

      // Empty ring, a few appends and reads, block 0 filled, one append to block 1, reads.
      dir_table[0]  = '{CMD_FETCH,  32'hFFFF_FFFF, 1'b1, '{1'b0, 3'd0, 4'd0, 32'h0, 1'b0}};
      dir_table[1]  = '{CMD_APPEND, 32'hFFFF_FFFF, 1'b1, '{1'b1, 3'd0, 4'd0, 32'h0, 1'b0}};
      dir_table[2]  = '{CMD_APPEND, 32'h0000_0000, 1'b1, '{1'b1, 3'd0, 4'd1, 32'h0, 1'b0}};
      dir_table[3]  = '{CMD_APPEND, 32'hA5A5_A5A5, 1'b1, '{1'b1, 3'd0, 4'd2, 32'h0, 1'b0}};
      dir_table[4]  = '{CMD_FETCH,  32'h0000_0000, 1'b1,
                        '{1'b1, 3'd0, 4'd0, 32'hFFFF_FFFF, 1'b0}};
      dir_table[5]  = '{CMD_FETCH,  32'h1234_5678, 1'b1, '{1'b1, 3'd0, 4'd1, 32'h0, 1'b0}};
      dir_table[6]  = '{CMD_FETCH,  32'h0000_0000, 1'b1,
                        '{1'b1, 3'd0, 4'd2, 32'hA5A5_A5A5, 1'b0}};
      dir_table[7]  = '{CMD_FETCH,  32'hFFFF_FFFF, 1'b1, '{1'b0, 3'd0, 4'd3, 32'h0, 1'b0}};
      dir_table[8]  = '{CMD_APPEND, 32'h8000_0000, 1'b0, '0};
      dir_table[9]  = '{CMD_APPEND, 32'h0000_0001, 1'b0, '0};
      dir_table[10] = '{CMD_APPEND, 32'h5A5A_5A5A, 1'b0, '0};
      dir_table[11] = '{CMD_APPEND, 32'h0F0F_0F0F, 1'b0, '0};
      dir_table[12] = '{CMD_APPEND, 32'hF0F0_F0F0, 1'b0, '0};
      dir_table[13] = '{CMD_APPEND, 32'h3333_3333, 1'b0, '0};
      dir_table[14] = '{CMD_APPEND, 32'hCCCC_CCCC, 1'b0, '0};
      dir_table[15] = '{CMD_APPEND, 32'h7FFF_FFFF, 1'b0, '0};
      dir_table[16] = '{CMD_APPEND, 32'hFFFF_FFFE, 1'b0, '0};
      dir_table[17] = '{CMD_APPEND, 32'h0001_0000, 1'b0, '0};
      dir_table[18] = '{CMD_APPEND, 32'hDEAD_BEEF, 1'b0, '0};
      dir_table[19] = '{CMD_APPEND, 32'h6666_9999, 1'b0, '0};
      dir_table[20] = '{CMD_APPEND, 32'hFFFF_FFFF, 1'b1, '{1'b1, 3'd0, 4'd15, 32'h0, 1'b0}};
      dir_table[21] = '{CMD_APPEND, 32'h5A5A_5A5A, 1'b1, '{1'b1, 3'd1, 4'd0, 32'h0, 1'b0}};
      dir_table[22] = '{CMD_FETCH,  32'h0000_0000, 1'b0, '0};
      dir_table[23] = '{CMD_FETCH,  32'hFFFF_FFFF, 1'b0, '0};

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < 24; i++) begin
         send_op(dir_table[i]);
         if ($urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
      end
      drain_responses();

      // Each phase draws its mix at random: append-heavy traffic, which laps the reader and
      // forces skips, a balanced mix, or fetch-heavy traffic, which runs the ring dry.
      sent     = 0;
      phase_no = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 3))
            0: append_pct = 90;
            1: append_pct = 70;
            2: append_pct = 50;
            default: append_pct = 15;
         endcase
         phase_len = $urandom_range(40, 220);
         while (phase_len > 0 && sent < RANDOM_ITEMS) begin
            burst_len = $urandom_range(1, 24);
            for (int k = 0; k < burst_len && phase_len > 0; k++) begin
               row            = '0;
               row.cmd        = ($urandom_range(1, 100) <= append_pct) ?
                                CMD_APPEND : CMD_FETCH;
               row.entry_data = $urandom();
               send_op(row);
               phase_len--;
               sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap != 0) begin
               start <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         // Hold off now and then until the block has answered everything.
         if (phase_no == 0 || $urandom_range(0, 2) == 0) begin
            drain_responses();
         end
         phase_no++;
      end

      drain_responses();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("block_ring_log_buffer_unit_tb: done, clean");
      end else begin
         $display("block_ring_log_buffer_unit_tb: done, errors");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/brlb_pkg.sv
hw/rtl/brlb_ram.sv
hw/rtl/brlb_ctrl.sv
hw/rtl/brlb_dpath.sv
hw/rtl/block_ring_log_buffer_unit.sv
tb/block_ring_log_buffer_unit_tb.sv
